FILE: rtl/delayed_coincidence_tagger_unit_assert.svh
`ifndef DELAYED_COINCIDENCE_TAGGER_UNIT_ASSERT_SVH
`define DELAYED_COINCIDENCE_TAGGER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DCTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DCTU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/dct_pkg.sv
package dct_pkg;

    // Slot store geometry
    localparam int NUM_SLOTS  = 32;
    localparam int GOOD_COUNT = 29;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    // Field widths
    localparam int CHAN_W    = 10;
    localparam int ENERGY_W  = 20;
    localparam int TIME_W    = 48;
    localparam int WINDOW_W  = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH  = 2'd2;

    // Register reset values: 67.71 min at 100 MHz, and 11.0216 keV +/- 2.49817 keV
    localparam logic [WINDOW_W-1:0] WINDOW_RESET      = 40'd406260000000;
    localparam logic [ENERGY_W-1:0] ENERGY_LOW_RESET  = 20'd2182;
    localparam logic [ENERGY_W-1:0] ENERGY_HIGH_RESET = 20'd3461;

    // Good raw channels; position in the list is the slot
    localparam logic [CHAN_W-1:0] GOOD_CHANNELS [0:GOOD_COUNT-1] = '{
        10'd646, 10'd644, 10'd642, 10'd630, 10'd628, 10'd626, 10'd624, 10'd632,
        10'd584, 10'd674, 10'd576, 10'd680, 10'd692, 10'd690, 10'd688, 10'd640,
        10'd676, 10'd616, 10'd614, 10'd610, 10'd664, 10'd662, 10'd656, 10'd696,
        10'd608, 10'd598, 10'd600, 10'd594, 10'd592
    };

    typedef struct packed {
        logic              good;
        logic [SLOT_W-1:0] slot;
    } slot_lookup_t;

    // Map a raw channel to its slot; the first match wins
    function automatic slot_lookup_t slot_of(input logic [CHAN_W-1:0] chan);
        slot_lookup_t res;
        res.good = 1'b0;
        res.slot = '0;
        for (int i = GOOD_COUNT - 1; i >= 0; i--)
        begin
            if (GOOD_CHANNELS[i] == chan)
            begin
                res.good = 1'b1;
                res.slot = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/dct_if.sv
interface dct_hit_if;
    import dct_pkg::*;
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   raw_channel;
    logic [ENERGY_W-1:0] hit_energy;
    logic [TIME_W-1:0]   hit_time;

    modport source (output valid, raw_channel, hit_energy, hit_time, input ready);
    modport sink   (input valid, raw_channel, hit_energy, hit_time, output ready);
endinterface

interface dct_tag_if;
    import dct_pkg::*;
    logic                valid;
    logic                ready;
    logic                good_channel;
    logic                prompt_tag;
    logic                delayed_tag;
    logic [WINDOW_W-1:0] elapsed_ticks;

    modport source (output valid, good_channel, prompt_tag, delayed_tag, elapsed_ticks,
                    input ready);
    modport sink   (input valid, good_channel, prompt_tag, delayed_tag, elapsed_ticks,
                    output ready);
endinterface

interface dct_cfg_if;
    import dct_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/delayed_coincidence_tagger_unit.sv
// A hit accepted at the input is held in the input stage, then in the result register that
// drives its tags; a stalled output holds both. Throughput: one hit per cycle while the output
// is not stalled; the slot read, time compare and slot update fall in the same cycle.
// Reset (rst_n low, asynchronous): pipeline emptied, all prompt-seen flags cleared at once,
// configuration registers back to their reset values. Slot times are undefined until written.
// The configuration channel takes a beat every cycle.
module delayed_coincidence_tagger_unit
    import dct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dct_hit_if.sink    hit,
    dct_tag_if.source  tag,
    dct_cfg_if.sink    cfg
);

    // Configuration registers
    logic [WINDOW_W-1:0] window_reg;
    logic [ENERGY_W-1:0] energy_low_reg;
    logic [ENERGY_W-1:0] energy_high_reg;

    // Input stage
    logic                s1_valid_reg;
    logic                s1_good_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [ENERGY_W-1:0] s1_energy_reg;
    logic [TIME_W-1:0]   s1_time_reg;

    // Slot store
    logic [TIME_W-1:0]    last_time_reg [0:NUM_SLOTS-1];
    logic [NUM_SLOTS-1:0] seen_reg;

    // Result stage
    logic                out_valid_reg;
    logic                out_good_reg;
    logic                out_prompt_reg;
    logic                out_delayed_reg;
    logic [WINDOW_W-1:0] out_elapsed_reg;

    logic                s1_advance;
    logic                s1_fire;
    slot_lookup_t        lookup;
    logic [TIME_W-1:0]   slot_time;
    logic [TIME_W:0]     time_diff;
    logic                later;
    logic                in_window;
    logic                prompt_next;
    logic                delayed_next;
    logic [WINDOW_W-1:0] elapsed_next;

    assign cfg.ready = 1'b1;

    // Write configuration registers on a cfg beat; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= WINDOW_RESET;
            energy_low_reg  <= ENERGY_LOW_RESET;
            energy_high_reg <= ENERGY_HIGH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_WINDOW_TICKS: window_reg      <= cfg.data[WINDOW_W-1:0];
                REG_ENERGY_LOW:   energy_low_reg  <= cfg.data[ENERGY_W-1:0];
                REG_ENERGY_HIGH:  energy_high_reg <= cfg.data[ENERGY_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance the input stage whenever the result register is free or being drained
    assign s1_advance = !out_valid_reg || tag.ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign hit.ready  = !s1_valid_reg || s1_advance;

    assign lookup = slot_of(hit.raw_channel);

    // Hold the input stage; resolve the slot on the way in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (hit.ready)
        begin
            s1_valid_reg <= hit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit.valid && hit.ready)
        begin
            s1_good_reg   <= lookup.good;
            s1_slot_reg   <= lookup.slot;
            s1_energy_reg <= hit.hit_energy;
            s1_time_reg   <= hit.hit_time;
        end
    end

    // Compare against the slot's last prompt time
    assign slot_time = last_time_reg[s1_slot_reg];
    assign time_diff = {1'b0, s1_time_reg} - {1'b0, slot_time};
    assign later     = !time_diff[TIME_W] && (time_diff[TIME_W-1:0] != '0);
    assign in_window = (time_diff[TIME_W-1:WINDOW_W] == '0)
                    && (time_diff[WINDOW_W-1:0] < window_reg);

    assign delayed_next = s1_good_reg && seen_reg[s1_slot_reg] && later && in_window;
    assign elapsed_next = delayed_next ? time_diff[WINDOW_W-1:0] : '0;
    assign prompt_next  = s1_good_reg && (s1_energy_reg > energy_low_reg)
                       && (s1_energy_reg < energy_high_reg);

    // Store the prompt time after the check, so a hit never matches itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (s1_fire && prompt_next)
        begin
            seen_reg[s1_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && prompt_next)
        begin
            last_time_reg[s1_slot_reg] <= s1_time_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_good_reg    <= s1_good_reg;
            out_prompt_reg  <= prompt_next;
            out_delayed_reg <= delayed_next;
            out_elapsed_reg <= elapsed_next;
        end
    end

    assign tag.valid         = out_valid_reg;
    assign tag.good_channel  = out_good_reg;
    assign tag.prompt_tag    = out_prompt_reg;
    assign tag.delayed_tag   = out_delayed_reg;
    assign tag.elapsed_ticks = out_elapsed_reg;

endmodule

FILE: rtl/dct_checker.sv
`include "delayed_coincidence_tagger_unit_assert.svh"

module dct_checker
    import dct_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                tag_valid,
    input logic                tag_ready,
    input logic                tag_good,
    input logic                tag_prompt,
    input logic                tag_delayed,
    input logic [WINDOW_W-1:0] tag_elapsed
);

    // No result beat is offered while in reset
    `DCTU_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |-> !tag_valid, "tag valid during reset")

    // A bad channel carries no tags
    `DCTU_ASSERT(a_bad_no_tags, tag_valid && !tag_good |-> !tag_prompt && !tag_delayed,
        "tags set on a bad channel")

    // Elapsed ticks are nonzero exactly when the hit is delayed
    `DCTU_ASSERT(a_elapsed_zero, tag_valid && !tag_delayed |-> tag_elapsed == '0,
        "elapsed ticks set without delayed tag")
    `DCTU_ASSERT(a_elapsed_nonzero, tag_valid && tag_delayed |-> tag_elapsed != '0,
        "delayed tag with zero elapsed ticks")

    // A stalled result beat holds
    `DCTU_ASSERT(a_stall_hold, tag_valid && !tag_ready |=> tag_valid && $stable(tag_good)
        && $stable(tag_prompt) && $stable(tag_delayed) && $stable(tag_elapsed),
        "stalled tag beat changed")

endmodule

bind delayed_coincidence_tagger_unit dct_checker u_dct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_valid   (tag.valid),
    .tag_ready   (tag.ready),
    .tag_good    (tag.good_channel),
    .tag_prompt  (tag.prompt_tag),
    .tag_delayed (tag.delayed_tag),
    .tag_elapsed (tag.elapsed_ticks)
);

FILE: tb/delayed_coincidence_tagger_unit_test.sv
module delayed_coincidence_tagger_unit_test;
    import dct_pkg::*;

    localparam int              SETTLE_CYCLES = 4;
    localparam int              STALL_LIMIT   = 2000;
    localparam int              SEG_HITS      = 140;
    localparam longint unsigned TIME_MAX      = (64'd1 << TIME_W) - 1;
    localparam longint unsigned ENERGY_MAX    = (64'd1 << ENERGY_W) - 1;
    localparam longint unsigned WINDOW_MAX    = (64'd1 << WINDOW_W) - 1;
    // Index past the last register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                good;
        logic                prompt;
        logic                delayed;
        logic [WINDOW_W-1:0] elapsed;
    } tag_beat_t;

    // Tracks per-slot prompt history and queues the tags each hit must produce
    class coincidence_board;
        logic [WINDOW_W-1:0] window_len;
        logic [ENERGY_W-1:0] e_lo;
        logic [ENERGY_W-1:0] e_hi;
        logic [TIME_W-1:0]   last_time [NUM_SLOTS];
        bit                  seen [NUM_SLOTS];
        tag_beat_t           expected [$];
        int                  errors;

        function new();
            window_len = WINDOW_RESET;
            e_lo       = ENERGY_LOW_RESET;
            e_hi       = ENERGY_HIGH_RESET;
            errors     = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                last_time[i] = '0;
                seen[i]      = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_WINDOW_TICKS: window_len = value[WINDOW_W-1:0];
                REG_ENERGY_LOW:   e_lo       = value[ENERGY_W-1:0];
                REG_ENERGY_HIGH:  e_hi       = value[ENERGY_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_hit(logic [CHAN_W-1:0] chan, logic [ENERGY_W-1:0] energy,
                               logic [TIME_W-1:0] stamp);
            tag_beat_t         exp;
            int                slot;
            logic [TIME_W-1:0] gap;
            exp  = '0;
            slot = -1;
            for (int i = 0; i < GOOD_COUNT; i++)
            begin
                if (slot < 0 && GOOD_CHANNELS[i] == chan)
                    slot = i;
            end
            if (slot >= 0)
            begin
                exp.good = 1'b1;
                // Match against the stored prompt before this hit can replace it
                if (seen[slot] && stamp > last_time[slot])
                begin
                    gap = stamp - last_time[slot];
                    if (gap < window_len)
                    begin
                        exp.delayed = 1'b1;
                        exp.elapsed = gap[WINDOW_W-1:0];
                    end
                end
                if (energy > e_lo && energy < e_hi)
                begin
                    exp.prompt      = 1'b1;
                    last_time[slot] = stamp;
                    seen[slot]      = 1'b1;
                end
            end
            expected = {expected, exp};
        endfunction

        function void check_tag(tag_beat_t got);
            tag_beat_t exp;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected tag beat good=%0b prompt=%0b delayed=%0b elapsed=%0d",
                         $time, got.good, got.prompt, got.delayed, got.elapsed);
                errors++;
            end
            else
            begin
                exp = expected.pop_front();
                if (got.good !== exp.good || got.prompt !== exp.prompt ||
                    got.delayed !== exp.delayed || got.elapsed !== exp.elapsed)
                begin
                    $display("%0t: tag mismatch: expected good=%0b prompt=%0b delayed=%0b elapsed=%0d",
                             $time, exp.good, exp.prompt, exp.delayed, exp.elapsed);
                    $display("%0t:                 actual good=%0b prompt=%0b delayed=%0b elapsed=%0d",
                             $time, got.good, got.prompt, got.delayed, got.elapsed);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dct_hit_if hit_bus ();
    dct_tag_if tag_bus ();
    dct_cfg_if cfg_bus ();

    coincidence_board board = new();

    int              hit_idle_pct;
    int              tag_idle_pct;
    longint unsigned now_tick;

    delayed_coincidence_tagger_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hit   (hit_bus),
        .tag   (tag_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the tag sink at random
    always @(negedge clk)
    begin
        tag_bus.ready = ($urandom_range(0, 99) >= tag_idle_pct);
    end

    // Check every tag beat against the oldest pending expectation
    always @(posedge clk)
    begin
        if (rst_n && tag_bus.valid === 1'b1 && tag_bus.ready === 1'b1)
            board.check_tag('{tag_bus.good_channel, tag_bus.prompt_tag,
                              tag_bus.delayed_tag, tag_bus.elapsed_ticks});
    end

    // Abort when no channel moves a beat for too long
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((hit_bus.valid && hit_bus.ready) || (tag_bus.valid && tag_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                stall = 0;
            else
                stall++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_hit(input logic [CHAN_W-1:0] chan, input logic [ENERGY_W-1:0] energy,
                            input logic [TIME_W-1:0] stamp);
        @(negedge clk);
        while ($urandom_range(0, 99) < hit_idle_pct)
        begin
            hit_bus.valid = 1'b0;
            @(negedge clk);
        end
        hit_bus.valid       = 1'b1;
        hit_bus.raw_channel = chan;
        hit_bus.hit_energy  = energy;
        hit_bus.hit_time    = stamp;
        do
            @(posedge clk);
        while (hit_bus.ready !== 1'b1);
        board.note_hit(chan, energy, stamp);
    endtask

    // Drop valid and hold until every pending tag has come back
    task automatic wait_drain(input int settle);
        @(negedge clk);
        hit_bus.valid = 1'b0;
        while (board.expected.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        hit_bus.valid = 1'b0;
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        board.set_reg(idx, value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Load all three registers; energy beats carry random junk above the field
    task automatic configure(input longint unsigned win, input longint unsigned lo,
                             input longint unsigned hi);
        wait_drain(SETTLE_CYCLES);
        write_reg(REG_WINDOW_TICKS, CFG_W'(win));
        write_reg(REG_ENERGY_LOW, {20'($urandom), ENERGY_W'(lo)});
        write_reg(REG_ENERGY_HIGH, {20'($urandom), ENERGY_W'(hi)});
    endtask

    // Random hits on a rising time line, aimed at the window edges now and then
    task automatic run_segment(input int count);
        longint unsigned w;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned r;
        longint unsigned delta;
        longint unsigned stamp;
        longint unsigned target;
        longint unsigned energy;
        logic [CHAN_W-1:0] chan;
        int pick;
        int slot;
        now_tick = 64'({16'($urandom_range(0, 16'hFFFF)), $urandom});
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                wait_drain(0);
            w    = 64'(board.window_len);
            lo   = 64'(board.e_lo);
            hi   = 64'(board.e_hi);
            r    = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
                chan = GOOD_CHANNELS[$urandom_range(0, GOOD_COUNT - 1)];
            else
                chan = CHAN_W'($urandom);
            stamp = now_tick;
            if (pick < 10)
                delta = 0;
            else if (pick < 15)
            begin
                // Step back in time without moving the time line
                delta = 0;
                if (now_tick >= 64)
                    stamp = now_tick - (r % 64);
            end
            else if (pick < 25)
            begin
                delta  = 0;
                slot   = $urandom_range(0, GOOD_COUNT - 1);
                target = 64'(board.last_time[slot]) + w - 1 + 64'($urandom_range(0, 2));
                if (board.seen[slot] && w > 0 && target <= TIME_MAX)
                begin
                    chan  = GOOD_CHANNELS[slot];
                    stamp = target;
                    if (target > now_tick)
                        now_tick = target;
                end
            end
            else if (pick < 30)
                delta = r % (2 * w + 2);
            else
                delta = r % (w / 8 + 2);
            if (delta != 0)
            begin
                now_tick = (TIME_MAX - now_tick < delta) ? TIME_MAX : now_tick + delta;
                stamp    = now_tick;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45 && hi > lo + 1)
                energy = lo + 1 + ({$urandom, $urandom} % (hi - lo - 1));
            else if (pick < 60)
            begin
                case ($urandom_range(0, 3))
                    0: energy = lo;
                    1: energy = lo + 1;
                    2: energy = hi - 1;
                    default: energy = hi;
                endcase
            end
            else
                energy = 64'($urandom);
            send_hit(chan, ENERGY_W'(energy), TIME_W'(stamp));
        end
    endtask

    initial
    begin
        longint unsigned w0;
        longint unsigned lo;
        longint unsigned hi;
        rst_n               = 1'b0;
        hit_bus.valid       = 1'b0;
        hit_bus.raw_channel = '0;
        hit_bus.hit_energy  = '0;
        hit_bus.hit_time    = '0;
        tag_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        hit_idle_pct        = 10;
        tag_idle_pct        = 61;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset registers, bad channels, energy bounds, time order, window edge
        w0 = 64'(WINDOW_RESET);
        send_hit(10'd0, 20'd2500, 48'd0);
        send_hit(10'h3FF, 20'hFFFFF, 48'hFFFF_FFFF_FFFF);
        send_hit(10'd645, 20'd2500, 48'd10);
        send_hit(10'd646, 20'd2182, 48'd100);
        send_hit(10'd646, 20'd2183, 48'd200);
        send_hit(10'd646, 20'd2183, 48'd200);
        send_hit(10'd646, 20'd3460, 48'd150);
        send_hit(10'd646, 20'd3461, TIME_W'(150 + w0 - 1));
        send_hit(10'd646, 20'd0, TIME_W'(150 + w0));
        send_hit(10'd576, 20'd3000, 48'd1000);
        send_hit(10'd576, 20'd3000, 48'd1001);
        send_hit(10'd696, 20'd2200, 48'd1002);
        send_hit(10'd592, 20'd3000, 48'd1003);
        send_hit(10'd592, 20'd0, TIME_W'(1003 + w0 - 2));

        // Zero window and crossed bounds; the unused index must change nothing
        configure(0, ENERGY_MAX, 0);
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        send_hit(10'd576, 20'd3000, 48'd2000);
        send_hit(10'd646, 20'hFFFFF, 48'd3000);

        // Widest window at the top of the time range
        configure(WINDOW_MAX, 0, 2);
        send_hit(10'd630, 20'd1, TIME_W'(TIME_MAX - WINDOW_MAX + 1));
        send_hit(10'd630, 20'd1, TIME_W'(TIME_MAX));
        send_hit(10'd628, 20'd1, TIME_W'(TIME_MAX - WINDOW_MAX));
        send_hit(10'd628, 20'd0, TIME_W'(TIME_MAX));

        // Bounds one apart leave no prompt energy
        configure(1000, 5, 6);
        send_hit(10'd624, 20'd5, 48'd4000);
        send_hit(10'd624, 20'd6, 48'd4001);

        // Random segments, sender idles lightly and the sink heavily
        configure(5000, 1000, 3000);
        run_segment(SEG_HITS);
        lo = 64'($urandom_range(0, 20'hFFFFF));
        hi = lo + 64'($urandom_range(2, 5000));
        if (hi > ENERGY_MAX)
            hi = ENERGY_MAX;
        configure(64'({8'($urandom), $urandom} | 40'd2), lo, hi);
        run_segment(SEG_HITS);

        // Swap the idling sides
        hit_idle_pct = 61;
        tag_idle_pct = 10;
        configure(WINDOW_MAX, 0, ENERGY_MAX);
        run_segment(SEG_HITS);
        configure(1, ENERGY_LOW_RESET, ENERGY_HIGH_RESET);
        run_segment(SEG_HITS);

        // Full rate on both sides
        hit_idle_pct = 0;
        tag_idle_pct = 0;
        configure(200, 10, 12);
        run_segment(SEG_HITS);
        configure(WINDOW_RESET, ENERGY_LOW_RESET, ENERGY_HIGH_RESET);
        run_segment(SEG_HITS);

        wait_drain(SETTLE_CYCLES);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/dct_pkg.sv
rtl/dct_if.sv
rtl/delayed_coincidence_tagger_unit.sv
rtl/dct_checker.sv
tb/delayed_coincidence_tagger_unit_test.sv
